// File: rtl/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication check, disabled during reset
`define CHK_IMPLY(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication check, disabled during reset
`define CHK_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`endif

// File: rtl/sha_pkg.sv
// Package: SHA-256 constants, types and message schedule functions
`default_nettype none
package sha_pkg;

    localparam int unsigned QueueDepth = 4;

    // Queue entry between front and back
    typedef struct packed {
        logic [7:0] msg_byte;
        logic       byte_present;
        logic       end_of_message;
    } sha_item_t;

    localparam logic [7:0] PadByte = 8'h80;

    function automatic logic [31:0] iv_word(input logic [2:0] i);
        logic [31:0] r;
        case (i)
            3'd0: r = 32'h6a09e667;
            3'd1: r = 32'hbb67ae85;
            3'd2: r = 32'h3c6ef372;
            3'd3: r = 32'ha54ff53a;
            3'd4: r = 32'h510e527f;
            3'd5: r = 32'h9b05688c;
            3'd6: r = 32'h1f83d9ab;
            3'd7: r = 32'h5be0cd19;
            default: r = 32'h0;
        endcase
        return r;
    endfunction

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] ror(input logic [31:0] v, input int unsigned s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] sig0(input logic [31:0] x);
        return ror(x, 7) ^ ror(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sig1(input logic [31:0] x);
        return ror(x, 17) ^ ror(x, 19) ^ (x >> 10);
    endfunction

endpackage
`default_nettype wire

// File: rtl/sha_queue.sv
// Small item queue between intake and hashing core
`default_nettype none
module sha_queue
    import sha_pkg::*;
#(
    parameter int unsigned DEPTH = QueueDepth
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      wr_valid,
    output logic           wr_ready,
    input  sha_item_t      wr_item,
    output logic           rd_valid,
    input  wire logic      rd_ready,
    output sha_item_t      rd_item
);
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    sha_item_t           mem_reg [DEPTH];
    logic [AW-1:0]       wp_reg, rp_reg;
    logic [AW:0]         cnt_reg;

    logic do_wr, do_rd;
    assign wr_ready = (cnt_reg != AW'(0) + (AW+1)'(DEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wp_reg] <= wr_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (do_wr) begin
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            end
            if (do_rd) begin
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end
endmodule
`default_nettype wire

// File: rtl/sha_core.sv
// Hashing core: block fill, padding, 64-round compression, digest output
`default_nettype none
module sha_core
    import sha_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  sha_item_t        in_item,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      out_word,
    output logic [2:0]       out_index,
    output logic             out_last
);
    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_PAD   = 7'b0000010,
        ST_LEN   = 7'b0000100,
        ST_LOAD  = 7'b0001000,
        ST_ROUND = 7'b0010000,
        ST_ADD   = 7'b0100000,
        ST_OUT   = 7'b1000000
    } state_t;

    state_t        state_reg;
    logic [31:0]   blk_reg [16];  // block buffer, big-endian words
    logic [5:0]    fill_reg;
    logic [63:0]   bits_reg;
    logic [31:0]   h_reg [8];
    logic [31:0]   v_reg [8];
    logic [31:0]   w_reg [16];
    logic [5:0]    rnd_reg;
    logic [3:0]    ld_reg;
    logic          fin_reg;   // this compression is the final one of the message
    logic          extra_reg; // another pad block (length only) follows
    logic          pad_reg;   // pad byte still owed after a full block ended the message
    logic [2:0]    oi_reg;

    // Message schedule next word and round datapath
    logic [31:0] w_new, t1, t2, s1e, s0a, ch, maj;
    assign w_new = sig1(w_reg[14]) + w_reg[9] + sig0(w_reg[1]) + w_reg[0];
    assign s1e = ror(v_reg[4], 6) ^ ror(v_reg[4], 11) ^ ror(v_reg[4], 25);
    assign ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
    assign t1  = v_reg[7] + s1e + ch + RoundK[rnd_reg] + w_reg[0];
    assign s0a = ror(v_reg[0], 2) ^ ror(v_reg[0], 13) ^ ror(v_reg[0], 22);
    assign maj = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
    assign t2  = s0a + maj;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);
    assign out_word  = h_reg[oi_reg];
    assign out_index = oi_reg;
    assign out_last  = (oi_reg == 3'd7);

    // byte lane of the fill slot; byte 0 of a word sits in the top bits
    logic [4:0] lane_sh;
    assign lane_sh = {~fill_reg[1:0], 3'b000};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fill_reg  <= '0;
            bits_reg  <= '0;
            rnd_reg   <= '0;
            ld_reg    <= '0;
            fin_reg   <= 1'b0;
            extra_reg <= 1'b0;
            pad_reg   <= 1'b0;
            oi_reg    <= '0;
            for (int i = 0; i < 8; i++) begin
                h_reg[i] <= iv_word(3'(i));
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        if (in_item.byte_present) begin
                            blk_reg[fill_reg[5:2]][lane_sh +: 8] <= in_item.msg_byte;
                            bits_reg <= bits_reg + 64'd8;
                            fill_reg <= fill_reg + 6'd1;
                        end
                        if (in_item.byte_present && fill_reg == 6'd63) begin
                            fin_reg   <= 1'b0;
                            extra_reg <= 1'b0;
                            pad_reg   <= in_item.end_of_message;
                            ld_reg    <= '0;
                            state_reg <= ST_LOAD;
                        end else if (in_item.end_of_message) begin
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD: begin
                    // fill_reg is the next free slot here; it is < 64 and wrapping is handled
                    blk_reg[fill_reg[5:2]][lane_sh +: 8] <= PadByte;
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63) begin
                        fin_reg <= 1'b0; extra_reg <= 1'b1;
                        ld_reg <= '0; state_reg <= ST_LOAD;
                    end else begin
                        state_reg <= ST_LEN;
                    end
                end
                ST_LEN: begin
                    // zero fill one byte per cycle, then length
                    if (fill_reg == 6'd56) begin
                        blk_reg[14] <= bits_reg[63:32];
                        blk_reg[15] <= bits_reg[31:0];
                        fill_reg <= '0;
                        fin_reg <= 1'b1; extra_reg <= 1'b0;
                        ld_reg <= '0; state_reg <= ST_LOAD;
                    end else begin
                        blk_reg[fill_reg[5:2]][lane_sh +: 8] <= 8'h00;
                        fill_reg <= fill_reg + 6'd1;
                        // length does not fit: close this block, length goes in the next
                        if (fill_reg == 6'd63) begin
                            fin_reg <= 1'b0; extra_reg <= 1'b1;
                            ld_reg <= '0; state_reg <= ST_LOAD;
                        end
                    end
                end
                ST_LOAD: begin
                    // one schedule word a cycle
                    w_reg[ld_reg] <= blk_reg[ld_reg];
                    ld_reg <= ld_reg + 4'd1;
                    if (ld_reg == 4'd15) begin
                        for (int i = 0; i < 8; i++) begin
                            v_reg[i] <= h_reg[i];
                        end
                        rnd_reg <= '0;
                        state_reg <= ST_ROUND;
                    end
                end
                ST_ROUND: begin
                    v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
                    v_reg[4] <= v_reg[3] + t1;
                    v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
                    v_reg[0] <= t1 + t2;
                    for (int i = 0; i < 15; i++) begin
                        w_reg[i] <= w_reg[i+1];
                    end
                    w_reg[15] <= w_new;
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= ST_ADD;
                    end
                end
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        h_reg[i] <= h_reg[i] + v_reg[i];
                    end
                    if (fin_reg) begin
                        oi_reg <= '0; state_reg <= ST_OUT;
                    end else if (pad_reg) begin
                        pad_reg <= 1'b0; state_reg <= ST_PAD;
                    end else if (extra_reg) begin
                        state_reg <= ST_LEN;
                    end else begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_OUT: begin
                    if (out_ready) begin
                        oi_reg <= oi_reg + 3'd1;
                        if (oi_reg == 3'd7) begin
                            for (int i = 0; i < 8; i++) begin
                                h_reg[i] <= iv_word(3'(i));
                            end
                            bits_reg  <= '0;
                            fill_reg  <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// File: rtl/sha256_stream_hasher_unit.sv
// Top level: SHA-256 hasher fed one byte per item
`default_nettype none
// SHA-256 over a byte stream. Each input item carries an optional byte and an
// end flag; on an end item (a bare end item with no bytes before it hashes the
// empty message) the unit pads, compresses and returns eight digest words, most
// significant first, then starts a new message from the initial hash. An intake
// queue of QUEUE_DEPTH items decouples the input from the hashing core, so up to
// QUEUE_DEPTH items can be taken while a block compresses. Each full block is
// loaded into the message schedule, run through its rounds (one round per cycle
// through a single round unit) and added into the hash state. Finalization adds
// the pad byte and zero bytes up to the length field, one or two compressions,
// and returns the digest words one at a time, each held until it is accepted.
module sha256_stream_hasher_unit
    import sha_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,  // [7:0] msg_byte
    input  wire logic [1:0]  s_tuser,  // [0] byte_present, [1] end_of_message
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // [31:0] digest_word, [34:32] word_index, zero fill
    output logic             m_tlast   // last_word
);
    sha_item_t wr_item, rd_item;
    logic      rd_valid, rd_ready;
    logic [31:0] word;
    logic [2:0]  idx;

    assign wr_item.msg_byte       = s_tdata;
    assign wr_item.byte_present   = s_tuser[0];
    assign wr_item.end_of_message = s_tuser[1];

    sha_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .aclk, .aresetn,
        .wr_valid (s_tvalid), .wr_ready (s_tready), .wr_item (wr_item),
        .rd_valid (rd_valid), .rd_ready (rd_ready), .rd_item (rd_item)
    );

    sha_core u_core (
        .aclk, .aresetn,
        .in_valid (rd_valid), .in_ready (rd_ready), .in_item (rd_item),
        .out_valid (m_tvalid), .out_ready (m_tready),
        .out_word (word), .out_index (idx), .out_last (m_tlast)
    );

    assign m_tdata = {5'b0, idx, word};
endmodule
`default_nettype wire

// File: rtl/sha_checker.sv
// Port-level checker for the hasher, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module sha_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [39:0] m_tdata,
    input wire logic        m_tlast
);
    `CHK_IMPLY(a_last_idx, aclk, aresetn, m_tvalid, (m_tlast == (m_tdata[34:32] == 3'd7)), "tlast mismatch")
    `CHK_IMPLY(a_pad_zero, aclk, aresetn, m_tvalid, (m_tdata[39:35] == 5'd0), "tdata fill not zero")
    `CHK_NEXT(a_idx_step, aclk, aresetn, m_tvalid && m_tready && !m_tlast, m_tvalid && (m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1), "word index skip")
    `CHK_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled word changed")
endmodule

bind sha256_stream_hasher_unit sha_checker u_sha_checker (
    .aclk, .aresetn, .m_tvalid, .m_tready, .m_tdata, .m_tlast
);
`default_nettype wire

// File: test/tb_top.sv
// Testbench for the SHA-256 byte-stream hasher: self-checking, with its own digest predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
    import sha_pkg::*;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;

    sha256_stream_hasher_unit u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  idx;
        logic        last;
    } digest_word_t;

    localparam int unsigned MaxCycles = 2000000;

    // Hash state of the predictor
    logic [31:0]  hash_h [8];
    logic [7:0]   blk [64];
    int unsigned  fill_pos;
    logic [63:0]  bit_len;
    digest_word_t digest_q [$];

    int unsigned  send_idle_pct = 0;
    int unsigned  recv_idle_pct = 0;
    int unsigned  hold_off_cycles = 0;
    int unsigned  mismatches = 0;
    int unsigned  cycle_count = 0;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int s);
        return (v >> s) | (v << (32 - s));
    endfunction

    function automatic logic [31:0] start_word(input int i);
        logic [31:0] iv [8];
        iv = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
               32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
        return iv[i];
    endfunction

    task automatic hash_block();
        logic [31:0] w [64];
        logic [31:0] r [8];
        logic [31:0] t1, t2, s0, s1;
        for (int i = 0; i < 16; i++)
            w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
        for (int i = 16; i < 64; i++) begin
            s0 = rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = s1 + w[i-7] + s0 + w[i-16];
        end
        for (int i = 0; i < 8; i++) r[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = r[7] + (rotr(r[4], 6) ^ rotr(r[4], 11) ^ rotr(r[4], 25))
                 + ((r[4] & r[5]) ^ (~r[4] & r[6])) + RoundK[i] + w[i];
            t2 = (rotr(r[0], 2) ^ rotr(r[0], 13) ^ rotr(r[0], 22))
                 + ((r[0] & r[1]) ^ (r[0] & r[2]) ^ (r[1] & r[2]));
            r[7] = r[6]; r[6] = r[5]; r[5] = r[4]; r[4] = r[3] + t1;
            r[3] = r[2]; r[2] = r[1]; r[1] = r[0]; r[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += r[i];
    endtask

    task automatic restart_message();
        for (int i = 0; i < 8; i++) hash_h[i] = start_word(i);
        fill_pos = 0;
        bit_len  = '0;
    endtask

    // Advance the predictor by one accepted item
    task automatic predict_item(input logic [7:0] b, input logic present, input logic eom);
        int unsigned p;
        digest_word_t d;
        if (present) begin
            blk[fill_pos] = b;
            bit_len += 64'd8;
            fill_pos = (fill_pos + 1) % 64;
            if (fill_pos == 0) hash_block();
        end
        if (!eom) return;
        p = fill_pos;
        blk[p] = PadByte;
        p++;
        if (p > 56) begin
            while (p < 64) begin
                blk[p] = 8'h00;
                p++;
            end
            hash_block();
            p = 0;
        end
        while (p < 56) begin
            blk[p] = 8'h00;
            p++;
        end
        for (int i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
        hash_block();
        for (int i = 0; i < 8; i++) begin
            d.word = hash_h[i];
            d.idx  = 3'(i);
            d.last = (i == 7);
            digest_q = {digest_q, d};
        end
        restart_message();
    endtask

    // Offer one item; returns at the edge that accepts it
    task automatic send_item(input logic [7:0] b, input logic present, input logic eom);
        @(negedge aclk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tdata  <= b;
        s_tuser  <= {eom, present};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        predict_item(b, present, eom);
    endtask

    task automatic send_message(input int unsigned len, input logic bare_end);
        for (int unsigned i = 0; i < len; i++) begin
            if (bare_end || i + 1 < len) send_item(8'($urandom), 1'b1, 1'b0);
            else send_item(8'($urandom), 1'b1, 1'b1);
        end
        if (bare_end || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (digest_q.size() != 0) @(negedge aclk);
    endtask

    // Directed: empty message, field extremes, idle items, pad edge lengths
    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);             // empty message
        send_item(8'hff, 1'b0, 1'b0);             // idle item, ignored
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);             // byte on the end item
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h55, 1'b0, 1'b0);
        send_item(8'haa, 1'b0, 1'b1);
        send_message(55, 1'b0);                   // length just fits
        send_message(56, 1'b0);                   // length spills to extra block
        send_message(64, 1'b0);                   // full block then pad block
        send_message(63, 1'b1);
        wait_drained();
    endtask

    // Random messages: mostly short, some across block boundaries, idle noise
    task automatic test_random(input int unsigned n_items);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(9))
                0: len = $urandom_range(130);
                1: len = 52 + $urandom_range(14);
                default: len = $urandom_range(12);
            endcase
            for (int unsigned i = 0; i < len; i++) begin
                if ($urandom_range(7) == 0) begin
                    send_item(8'($urandom), 1'b0, 1'b0);
                    sent++;
                end
                send_item(8'($urandom), 1'b1, 1'b0);
            end
            send_item(8'($urandom), 1'($urandom_range(1)), 1'b1);
            sent += len + 1;
        end
        wait_drained();
    endtask

    // Receiver holds off a long time while bytes keep arriving
    task automatic test_backpressure();
        hold_off_cycles = 300;
        send_message(20, 1'b0);
        send_message(70, 1'b0);
        wait_drained();
    endtask

    // Result ready: random stalls plus the long hold-off
    always @(negedge aclk) begin
        if (hold_off_cycles != 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= !(recv_idle_pct != 0 && $urandom_range(99) < recv_idle_pct);
        end
    end

    // Compare each accepted digest word with the oldest prediction
    always @(posedge aclk) begin
        digest_word_t exp_w;
        if (aresetn && m_tvalid && m_tready) begin
            if (digest_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected digest word %h idx %0d", m_tdata[31:0], m_tdata[34:32]);
            end else begin
                exp_w = digest_q.pop_front();
                if (m_tdata[31:0] !== exp_w.word || m_tdata[34:32] !== exp_w.idx
                        || m_tlast !== exp_w.last) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b",
                                 exp_w.word, exp_w.idx, exp_w.last,
                                 m_tdata[31:0], m_tdata[34:32], m_tlast);
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MaxCycles) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        restart_message();
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        test_directed();
        send_idle_pct = 23; recv_idle_pct = 57;
        test_random(30);
        send_idle_pct = 57; recv_idle_pct = 23;
        test_random(30);
        send_idle_pct = 0; recv_idle_pct = 0;
        test_random(30);
        test_backpressure();
        repeat (200) @(negedge aclk);
        if (mismatches == 0 && digest_q.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end
endmodule
`default_nettype wire
